>>> hw/rtl/ecosc_pkg.sv
// Shared types, widths, register indexes and the sine table builder for the
// exponential chirp oscillator. Used by every module in hw/rtl.
`timescale 1ns / 1ps

package ecosc_pkg;

  // Default parameter values
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_WIDTH_DEF    = 24;

  // Fixed field widths
  localparam int PHASE_W     = 32;
  localparam int INC_W       = 32;
  localparam int IDX_W       = 24;
  localparam int START_INC_W = 31;
  localparam int RATIO_W     = 32;
  localparam int AMP_W       = 16;
  localparam int SINE_W      = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Fraction bits of the ratio (Q2.30) and of sine times gain (Q15 x Q15)
  localparam int RATIO_FRAC = 30;
  localparam int GAIN_FRAC  = 30;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_INC    = 3'd0,
    CFG_SWEEP_RATIO  = 3'd1,
    CFG_AMPLITUDE    = 3'd2,
    CFG_START_PHASE  = 3'd3,
    CFG_SAMPLE_COUNT = 3'd4
  } cfg_reg_t;

  // Configuration reset values
  localparam logic [START_INC_W-1:0] START_INC_RST    = '0;
  localparam logic [RATIO_W-1:0]     SWEEP_RATIO_RST  = 32'd1073741824;
  localparam logic [AMP_W-1:0]       AMPLITUDE_RST    = 16'd32768;
  localparam logic [PHASE_W-1:0]     START_PHASE_RST  = 32'd1073741824;
  localparam logic [IDX_W-1:0]       SAMPLE_COUNT_RST = 24'd48000;

  // Sweep state kept in the state memory
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [INC_W-1:0]   inc;
    logic [IDX_W-1:0]   idx;
  } sweep_state_t;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave sine point j of 2^qbits, Q1.15 magnitude (elaboration only)
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned j,
                                                      input int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned prod;
    longint unsigned r;
    longint          sum;
    x    = (HALF_PI_Q30 * longint'(j) + ((64'd1 << qbits) >> 1)) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      prod = (term * x2) >> 30;
      // divide by (2k)(2k+1)
      case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        default: term = prod / 64'd156;
      endcase
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

>>> hw/rtl/ecosc_state_mem.sv
// Single-entry sweep state memory with registered read and write forwarding.
// Depends on ecosc_pkg for the state record.
`timescale 1ns / 1ps

module ecosc_state_mem (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  ecosc_pkg::sweep_state_t  wr_data,
  output ecosc_pkg::sweep_state_t  rd_data
);

  ecosc_pkg::sweep_state_t mem [1];
  ecosc_pkg::sweep_state_t rd_data_r;
  ecosc_pkg::sweep_state_t fwd_data_r;
  logic                    mem_valid_r;
  logic                    rd_valid_r;
  logic                    fwd_valid_r;

  // Write the entry and read it back every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[0] <= wr_data;
    end
    rd_data_r  <= mem[0];
    fwd_data_r <= wr_data;
  end

  // Track whether the entry holds data and whether the read is stale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_valid_r <= 1'b0;
      rd_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      mem_valid_r <= mem_valid_r | wr_en;
      rd_valid_r  <= mem_valid_r;
      fwd_valid_r <= wr_en;
    end
  end

  // Forward the last write; an unwritten entry reads as zero
  assign rd_data = fwd_valid_r ? fwd_data_r :
                   (rd_valid_r ? rd_data_r : '0);

endmodule

>>> hw/rtl/ecosc_sine_rom.sv
// Quarter-wave sine table with registered read.
// Contents built at elaboration by ecosc_pkg::quarter_sine.
`timescale 1ns / 1ps

module ecosc_sine_rom #(
  parameter int SINE_TABLE_BITS = ecosc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [SINE_TABLE_BITS-2:0]        addr,
  output logic [ecosc_pkg::SINE_W-1:0]      data
);

  localparam int QBITS  = SINE_TABLE_BITS - 2;
  localparam int DEPTH  = (1 << QBITS) + 1;

  logic [ecosc_pkg::SINE_W-1:0] tab [DEPTH];
  logic [ecosc_pkg::SINE_W-1:0] data_r;

  // Constant table entries
  for (genvar i = 0; i < DEPTH; i++) begin : g_tab
    localparam logic [ecosc_pkg::SINE_W-1:0] Val =
      ecosc_pkg::quarter_sine(i, QBITS);
    assign tab[i] = Val;
  end

  // Registered lookup
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= tab[addr];
    end
  end

  assign data = data_r;

endmodule

>>> hw/rtl/ecosc_mixer.sv
// Tone path: sine lookup, gain multiply, rounding, mix with base, saturate.
// Holds the output register. Depends on ecosc_pkg and ecosc_sine_rom.
`timescale 1ns / 1ps

module ecosc_mixer #(
  parameter int SINE_TABLE_BITS = ecosc_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_WIDTH    = ecosc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [SINE_TABLE_BITS-2:0]        req_addr,
  input  logic                              req_neg,
  input  logic                              req_last,
  input  logic signed [SAMPLE_WIDTH-1:0]    req_base,
  input  logic [ecosc_pkg::AMP_W-1:0]       amplitude,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    out_mixed_sample,
  output logic                              out_last
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int PROD_W = ecosc_pkg::SINE_W + ecosc_pkg::AMP_W;
  localparam int SCL_W  = PROD_W + W - 1;
  localparam int MAG_W  = SCL_W + 1 - ecosc_pkg::GAIN_FRAC;
  localparam int SUM_W  = W + 2;
  localparam int RND_POS = ecosc_pkg::GAIN_FRAC - 1;

  localparam logic [SCL_W:0] RndHalf =
    {{(SCL_W - RND_POS){1'b0}}, 1'b1, {RND_POS{1'b0}}};
  localparam logic signed [SUM_W-1:0] SatMax = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SatMin = {3'b111, {(W-1){1'b0}}};

  logic                             req_acc;
  logic                             s2_v_r;
  logic                             s2_neg_r;
  logic                             s2_last_r;
  logic signed [W-1:0]              s2_base_r;
  logic [ecosc_pkg::SINE_W-1:0]     s2_sine;
  logic                             s2_move;
  logic                             s3_v_r;
  logic                             s3_neg_r;
  logic                             s3_last_r;
  logic signed [W-1:0]              s3_base_r;
  logic [PROD_W-1:0]                s3_prod_r;
  logic                             s3_move;
  logic                             out_free;
  logic                             out_v_r;
  logic signed [W-1:0]              out_mixed_r;
  logic                             out_last_r;
  logic [SCL_W:0]                   rounded;
  logic [MAG_W-1:0]                 mag;
  logic signed [SUM_W-1:0]          tone;
  logic signed [SUM_W-1:0]          sum;
  logic signed [W-1:0]              sat;

  // Stage movement: each stage takes data when empty or draining
  assign out_free  = !out_v_r || !out_stall;
  assign s3_move   = s3_v_r && out_free;
  assign s2_move   = s2_v_r && (!s3_v_r || s3_move);
  assign req_ready = !s2_v_r || s2_move;
  assign req_acc   = req_valid && req_ready;

  ecosc_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .rd_en(req_acc),
    .addr (req_addr),
    .data (s2_sine)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (req_acc) begin
        s2_v_r <= 1'b1;
      end else if (s2_move) begin
        s2_v_r <= 1'b0;
      end
      if (s2_move) begin
        s3_v_r <= 1'b1;
      end else if (s3_move) begin
        s3_v_r <= 1'b0;
      end
      if (s3_move) begin
        out_v_r <= 1'b1;
      end else if (out_free) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      s2_neg_r  <= req_neg;
      s2_last_r <= req_last;
      s2_base_r <= req_base;
    end
    if (s2_move) begin
      s3_prod_r <= PROD_W'(s2_sine) * PROD_W'(amplitude);
      s3_neg_r  <= s2_neg_r;
      s3_last_r <= s2_last_r;
      s3_base_r <= s2_base_r;
    end
    if (s3_move) begin
      out_mixed_r <= sat;
      out_last_r  <= s3_last_r;
    end
  end

  // Scale to full range, round half away from zero on the magnitude
  assign rounded = {1'b0, s3_prod_r, {(W-1){1'b0}}} + RndHalf;
  assign mag     = rounded[SCL_W -: MAG_W];
  assign tone    = s3_neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Mix and clamp to the sample range
  assign sum = $signed({{2{s3_base_r[W-1]}}, s3_base_r}) + tone;
  always_comb begin
    if (sum > SatMax) begin
      sat = SatMax[W-1:0];
    end else if (sum < SatMin) begin
      sat = SatMin[W-1:0];
    end else begin
      sat = sum[W-1:0];
    end
  end

  assign out_valid        = out_v_r;
  assign out_mixed_sample = out_mixed_r;
  assign out_last         = out_last_r;

endmodule

>>> hw/rtl/exponential_chirp_oscillator.sv
// Exponential chirp oscillator: after the input transfer, a result passes the
// sweep stage, table read, gain multiply and output register in that order.
// Throughput one item per cycle while out_stall is low, set by the increment
// update (32x32 multiply) that loops through the state memory's forwarding path.
// Reset (rst_n low, synchronous) empties the pipeline, loads register
// defaults and makes the sweep state read as zero until first written.
`timescale 1ns / 1ps

module exponential_chirp_oscillator #(
  parameter int SINE_TABLE_BITS = ecosc_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_WIDTH    = ecosc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ecosc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecosc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_base_sample,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_mixed_sample,
  output logic                                out_last
);

  localparam int T      = SINE_TABLE_BITS;
  localparam int IDX_W  = ecosc_pkg::IDX_W;
  localparam int INC_W  = ecosc_pkg::INC_W;
  localparam int MUL_W  = INC_W + ecosc_pkg::RATIO_W;
  localparam int FRAC   = ecosc_pkg::RATIO_FRAC;
  localparam int SHR_W  = MUL_W - FRAC;

  localparam logic [MUL_W-1:0] IncRnd = {{(MUL_W - FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic [T-2:0]     QuarterSize = {1'b1, {(T-2){1'b0}}};

  logic [ecosc_pkg::START_INC_W-1:0] start_inc_r;
  logic [ecosc_pkg::RATIO_W-1:0]     sweep_ratio_r;
  logic [ecosc_pkg::AMP_W-1:0]       amplitude_r;
  logic [ecosc_pkg::PHASE_W-1:0]     start_phase_r;
  logic [IDX_W-1:0]                  sample_count_r;

  logic                              s1_v_r;
  logic signed [SAMPLE_WIDTH-1:0]    s1_base_r;
  logic                              s1_restart_r;
  logic                              in_acc;
  logic                              s1_move;
  logic                              mix_ready;

  ecosc_pkg::sweep_state_t           cur_state;
  ecosc_pkg::sweep_state_t           wr_data;
  logic                              sweep_start;
  logic [ecosc_pkg::PHASE_W-1:0]     eff_phase;
  logic [INC_W-1:0]                  eff_inc;
  logic [IDX_W-1:0]                  eff_idx;
  logic [IDX_W:0]                    idx_inc;
  logic                              last;
  logic [MUL_W-1:0]                  inc_prod;
  logic [SHR_W-1:0]                  inc_shr;
  logic [INC_W-1:0]                  next_inc;
  logic [T-1:0]                      tab_idx;
  logic [T-3:0]                      quarter_j;
  logic [T-2:0]                      rom_addr;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_inc_r    <= ecosc_pkg::START_INC_RST;
      sweep_ratio_r  <= ecosc_pkg::SWEEP_RATIO_RST;
      amplitude_r    <= ecosc_pkg::AMPLITUDE_RST;
      start_phase_r  <= ecosc_pkg::START_PHASE_RST;
      sample_count_r <= ecosc_pkg::SAMPLE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecosc_pkg::CFG_START_INC:    start_inc_r    <= cfg_data[ecosc_pkg::START_INC_W-1:0];
        ecosc_pkg::CFG_SWEEP_RATIO:  sweep_ratio_r  <= cfg_data[ecosc_pkg::RATIO_W-1:0];
        ecosc_pkg::CFG_AMPLITUDE:    amplitude_r    <= cfg_data[ecosc_pkg::AMP_W-1:0];
        ecosc_pkg::CFG_START_PHASE:  start_phase_r  <= cfg_data[ecosc_pkg::PHASE_W-1:0];
        ecosc_pkg::CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Input transfer into the sweep stage
  assign s1_move  = s1_v_r && mix_ready;
  assign in_stall = s1_v_r && !mix_ready;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_base_r    <= in_base_sample;
      s1_restart_r <= in_restart;
    end
  end

  // Sweep state read, update on advance
  ecosc_state_mem u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (s1_move),
    .wr_data(wr_data),
    .rd_data(cur_state)
  );

  // Start a new sweep on restart or when the index has wrapped
  assign sweep_start = s1_restart_r || (cur_state.idx == '0);
  assign eff_phase   = sweep_start ? start_phase_r + {1'b0, start_inc_r} : cur_state.phase;
  assign eff_inc     = sweep_start ? {1'b0, start_inc_r} : cur_state.inc;
  assign eff_idx     = sweep_start ? '0 : cur_state.idx;

  // End-of-sweep flag
  assign idx_inc = {1'b0, eff_idx} + 1'b1;
  assign last    = idx_inc >= {1'b0, sample_count_r};

  // Advance the step by the ratio, rounded, clamped to 32 bits
  assign inc_prod = MUL_W'(eff_inc) * MUL_W'(sweep_ratio_r) + IncRnd;
  assign inc_shr  = inc_prod[MUL_W-1:FRAC];
  assign next_inc = (|inc_shr[SHR_W-1:INC_W]) ? '1 : inc_shr[INC_W-1:0];

  assign wr_data.phase = eff_phase + eff_inc;
  assign wr_data.inc   = next_inc;
  assign wr_data.idx   = last ? '0 : idx_inc[IDX_W-1:0];

  // Fold the phase into a quarter-wave address and a sign
  assign tab_idx   = eff_phase[ecosc_pkg::PHASE_W-1 -: T];
  assign quarter_j = tab_idx[T-3:0];
  assign rom_addr  = tab_idx[T-2] ? QuarterSize - {1'b0, quarter_j} : {1'b0, quarter_j};

  ecosc_mixer #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_mixer (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (s1_v_r),
    .req_ready       (mix_ready),
    .req_addr        (rom_addr),
    .req_neg         (tab_idx[T-1]),
    .req_last        (last),
    .req_base        (s1_base_r),
    .amplitude       (amplitude_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mixed_sample(out_mixed_sample),
    .out_last        (out_last)
  );

  // A restarted sweep advances from the start phase by two start steps
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && s1_restart_r |-> wr_data.phase == start_phase_r + {start_inc_r, 1'b0})
    else $error("restart phase update wrong");

  // The state seen after a write is the data written
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> cur_state == $past(wr_data))
    else $error("state forwarding lost a write");

  // The stored index stays inside the sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |-> (wr_data.idx < sample_count_r) || (wr_data.idx == '0))
    else $error("sample index past sweep length");

  // An empty sweep stage never holds off the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("input stalled with empty stage");

endmodule
